>>> src/assert_macros.svh
// Assertion helpers used by the polar measurement and Jacobian core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define PMJ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define PMJ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pmj_pkg.sv
// ----------------------------------------------------------------------------
// pmj_pkg
// Widths, constants, helper functions and carried-data types of the polar
// measurement and Jacobian core.
// ----------------------------------------------------------------------------
package pmj_pkg;

	localparam int WORD_W       = 32;
	localparam int FRAC_W       = 16;
	localparam int RANGE_W      = 31;
	localparam int UNIT_W       = 18;
	localparam int FLOOR_W      = 16;
	localparam int ROOT_STEPS   = 32;
	localparam int QUOT_BITS    = 31;
	localparam int DIV_LAT      = QUOT_BITS + 1;
	localparam int CORDIC_STEPS = 31;
	localparam int CORDIC_W     = 36;
	localparam int ROUND_SH     = 30 - FRAC_W;
	localparam int PIPE_LAT     = 3 + ROOT_STEPS + 2 + DIV_LAT;

	localparam logic [FLOOR_W-1:0] SPEED_FLOOR_RST = 16'd7;
	localparam logic signed [CORDIC_W-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 36'sd1 <<< (ROUND_SH - 1);
	localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic [63:0] s;
		logic [63:0] num_mag;
		logic        num_neg;
		logic [63:0] d_mag;
		logic        d_neg;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] vx;
		logic [31:0] vy;
		logic        origin;
	} side_t;

	typedef struct packed {
		logic [31:0] r;
		logic [63:0] s;
		logic [63:0] num_mag;
		logic        num_neg;
		logic        d_neg;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] vx;
		logic [31:0] vy;
		logic        origin;
	} mid_t;

	typedef struct packed {
		logic               origin;
		logic               vfast;
		logic [RANGE_W-1:0] range;
	} tail_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic signed [CORDIC_W-1:0] cordic_angle(input int i);
		logic signed [CORDIC_W-1:0] a;
		case (i)
			0: a = 36'sd843314857;
			1: a = 36'sd497837829;
			2: a = 36'sd263043837;
			3: a = 36'sd133525159;
			4: a = 36'sd67021687;
			5: a = 36'sd33543516;
			6: a = 36'sd16775851;
			7: a = 36'sd8388437;
			8: a = 36'sd4194283;
			9: a = 36'sd2097149;
			default: a = 36'sd1 <<< (30 - i);
		endcase
		return a;
	endfunction

endpackage

>>> src/pmj_chan_if.sv
// ----------------------------------------------------------------------------
// pmj channel interfaces
// Valid/ready channels for track states in and measurement items out.
// ----------------------------------------------------------------------------
interface pmj_track_if import pmj_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] pos_x;
	logic signed [WORD_W-1:0] vel_x;
	logic signed [WORD_W-1:0] pos_y;
	logic signed [WORD_W-1:0] vel_y;

	modport source (output valid, pos_x, vel_x, pos_y, vel_y, input ready);
	modport sink (input valid, pos_x, vel_x, pos_y, vel_y, output ready);
endinterface

interface pmj_meas_if import pmj_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] bearing;
	logic [RANGE_W-1:0]       range;
	logic signed [WORD_W-1:0] range_rate;
	logic signed [WORD_W-1:0] dbearing_dx;
	logic signed [WORD_W-1:0] dbearing_dy;
	logic signed [UNIT_W-1:0] drange_dx;
	logic signed [UNIT_W-1:0] drange_dy;
	logic signed [WORD_W-1:0] drate_dx;
	logic signed [WORD_W-1:0] drate_dy;
	logic signed [UNIT_W-1:0] drate_dvx;
	logic signed [UNIT_W-1:0] drate_dvy;
	logic                     at_origin;

	modport source (output valid, bearing, range, range_rate, dbearing_dx, dbearing_dy,
		drange_dx, drange_dy, drate_dx, drate_dy, drate_dvx, drate_dvy, at_origin,
		input ready);
	modport sink (input valid, bearing, range, range_rate, dbearing_dx, dbearing_dy,
		drange_dx, drange_dy, drate_dx, drate_dy, drate_dvx, drate_dvy, at_origin,
		output ready);
endinterface

>>> src/pmj_isqrt.sv
// ----------------------------------------------------------------------------
// pmj_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pmj_isqrt import pmj_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] sq,
	output logic [31:0] root
);

	logic [63:0] n_s [ROOT_STEPS];
	logic [63:0] r_s [ROOT_STEPS];

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] n_p;
		logic [63:0] r_p;
		logic [63:0] t;

		if (j == 0) begin : g_first
			assign n_p = sq;
			assign r_p = '0;
		end else begin : g_next
			assign n_p = n_s[j-1];
			assign r_p = r_s[j-1];
		end

		assign t = r_p + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (n_p >= t) begin
					n_s[j] <= n_p - t;
					r_s[j] <= (r_p >> 1) + BIT;
				end else begin
					n_s[j] <= n_p;
					r_s[j] <= r_p >> 1;
				end
			end
		end
	end

	assign root = r_s[ROOT_STEPS-1][31:0];

endmodule

>>> src/pmj_div.sv
// ----------------------------------------------------------------------------
// pmj_div
// Pipelined restoring divider of magnitudes: an overflow check stage, then one
// quotient bit per stage; signed quotient truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module pmj_div import pmj_pkg::*; #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic              neg,
	output logic [WORD_W-1:0] quot
);

	localparam int CMP_W = ((NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS) + 1;

	logic [CMP_W-1:0]     rem_s [DIV_LAT];
	logic [DEN_W-1:0]     den_s [DIV_LAT];
	logic [QUOT_BITS-1:0] quo_s [DIV_LAT];
	logic                 ovf_s [DIV_LAT];
	logic                 neg_s [DIV_LAT];
	logic [WORD_W-1:0]    mag;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CMP_W'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << QUOT_BITS);
			neg_s[0] <= neg;
		end
	end

	for (genvar j = 1; j < DIV_LAT; j++) begin : g_bit
		localparam int B = QUOT_BITS - j;
		logic [CMP_W-1:0] trial;

		assign trial = CMP_W'(den_s[j-1]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
				if (rem_s[j-1] >= trial) begin
					rem_s[j] <= rem_s[j-1] - trial;
					quo_s[j] <= quo_s[j-1] | (QUOT_BITS'(1) << B);
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
			end
		end
	end

	assign mag = {1'b0, quo_s[DIV_LAT-1]};

	always_comb begin
		if (ovf_s[DIV_LAT-1]) begin
			quot = neg_s[DIV_LAT-1] ? SAT_NEG : SAT_POS;
		end else begin
			quot = neg_s[DIV_LAT-1] ? (~mag + 1'b1) : mag;
		end
	end

endmodule

>>> src/polar_measurement_and_jacobian_core.sv
// ----------------------------------------------------------------------------
// polar_measurement_and_jacobian_core
// Bearing, range, range rate and the nonzero measurement Jacobian entries of
// one tracked target state, in Q16.16 (signed; range unsigned, 31 bits).
//
// Channel   Role   Payload
// track     sink   pos_x, vel_x, pos_y, vel_y
// meas      source bearing, range, range_rate, eight Jacobian terms, at_origin
// cfg       write  speed_floor (cfg_we, cfg_wdata)
//
// One item enters per cycle while no result waits unaccepted at the output.
// Each item passes through the 32-stage square root followed by the 32-stage
// dividers, with the CORDIC running beside the dividers.
// Reset clears all valid flags and sets speed_floor to 7.
// While a result waits at the output the whole pipeline holds.
// ----------------------------------------------------------------------------
module polar_measurement_and_jacobian_core import pmj_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FLOOR_W-1:0] cfg_wdata,
	pmj_track_if.sink          track,
	pmj_meas_if.source         meas
);

	`include "assert_macros.svh"

	logic               en;
	logic               fire;
	logic [FLOOR_W-1:0] speed_floor_q;
	logic [PIPE_LAT-1:0] vld_s;
	logic               vld_s70;

	logic signed [31:0] x_s1, y_s1, vx_s1, vy_s1;
	logic               origin_s1;

	logic signed [63:0] xx_s2, yy_s2, vxvx_s2, vyvy_s2, xvx_s2, yvy_s2, xvy_s2, yvx_s2;
	logic [31:0]        x_s2, y_s2, vx_s2, vy_s2;
	logic               origin_s2;

	logic signed [64:0] num_w, d_w;
	logic [63:0]        sq_s3;
	side_t              side_s3;
	side_t              side_s [ROOT_STEPS];
	logic [31:0]        root;

	logic [63:0] sr_lo_s36, sr_hi_s36, yd_lo_s36, yd_hi_s36, xd_lo_s36, xd_hi_s36;
	mid_t        mid_s36, mid_s37;
	logic [95:0] den3_s37, yd_s37, xd_s37;
	logic [31:0] xm, ym, vxm, vym;

	logic signed [CORDIC_W-1:0] cx_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cy_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cz_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] xw, yw, bsum;
	tail_t                      tail_s [DIV_LAT];

	logic [WORD_W-1:0] q_rr, q_dbx, q_dby, q_drx, q_dry, q_drdx, q_drdy;
	logic [WORD_W-1:0] bear;

	assign en          = !vld_s70 || meas.ready;
	assign track.ready = en;
	assign fire        = track.valid && en;
	assign meas.valid  = vld_s70;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_floor_q <= SPEED_FLOOR_RST;
		end else if (cfg_we) begin
			speed_floor_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s70 <= 1'b0;
		end else if (en) begin
			vld_s   <= {vld_s[PIPE_LAT-2:0], fire};
			vld_s70 <= vld_s[PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1      <= track.pos_x;
			y_s1      <= track.pos_y;
			vx_s1     <= track.vel_x;
			vy_s1     <= track.vel_y;
			origin_s1 <= (track.pos_x == '0) && (track.pos_y == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2     <= x_s1 * x_s1;
			yy_s2     <= y_s1 * y_s1;
			vxvx_s2   <= vx_s1 * vx_s1;
			vyvy_s2   <= vy_s1 * vy_s1;
			xvx_s2    <= x_s1 * vx_s1;
			yvy_s2    <= y_s1 * vy_s1;
			xvy_s2    <= x_s1 * vy_s1;
			yvx_s2    <= y_s1 * vx_s1;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			vx_s2     <= vx_s1;
			vy_s2     <= vy_s1;
			origin_s2 <= origin_s1;
		end
	end

	assign num_w = {xvx_s2[63], xvx_s2} + {yvy_s2[63], yvy_s2};
	assign d_w   = {xvy_s2[63], xvy_s2} - {yvx_s2[63], yvx_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= origin_s2 ? (64'(vxvx_s2) + 64'(vyvy_s2)) : (64'(xx_s2) + 64'(yy_s2));
			side_s3.s       <= 64'(xx_s2) + 64'(yy_s2);
			side_s3.num_neg <= num_w[64];
			side_s3.num_mag <= num_w[64] ? 64'(~num_w + 65'sd1) : num_w[63:0];
			side_s3.d_neg   <= d_w[64];
			side_s3.d_mag   <= d_w[64] ? 64'(~d_w + 65'sd1) : d_w[63:0];
			side_s3.x       <= x_s2;
			side_s3.y       <= y_s2;
			side_s3.vx      <= vx_s2;
			side_s3.vy      <= vy_s2;
			side_s3.origin  <= origin_s2;
		end
	end

	pmj_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sq   (sq_s3),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s3;
			for (int k = 1; k < ROOT_STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_lo_s36 <= side_s[ROOT_STEPS-1].s[31:0] * root;
			sr_hi_s36 <= side_s[ROOT_STEPS-1].s[63:32] * root;
			yd_lo_s36 <= mag32(side_s[ROOT_STEPS-1].y) * side_s[ROOT_STEPS-1].d_mag[31:0];
			yd_hi_s36 <= mag32(side_s[ROOT_STEPS-1].y) * side_s[ROOT_STEPS-1].d_mag[63:32];
			xd_lo_s36 <= mag32(side_s[ROOT_STEPS-1].x) * side_s[ROOT_STEPS-1].d_mag[31:0];
			xd_hi_s36 <= mag32(side_s[ROOT_STEPS-1].x) * side_s[ROOT_STEPS-1].d_mag[63:32];
			mid_s36.r       <= root;
			mid_s36.s       <= side_s[ROOT_STEPS-1].s;
			mid_s36.num_mag <= side_s[ROOT_STEPS-1].num_mag;
			mid_s36.num_neg <= side_s[ROOT_STEPS-1].num_neg;
			mid_s36.d_neg   <= side_s[ROOT_STEPS-1].d_neg;
			mid_s36.x       <= side_s[ROOT_STEPS-1].x;
			mid_s36.y       <= side_s[ROOT_STEPS-1].y;
			mid_s36.vx      <= side_s[ROOT_STEPS-1].vx;
			mid_s36.vy      <= side_s[ROOT_STEPS-1].vy;
			mid_s36.origin  <= side_s[ROOT_STEPS-1].origin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den3_s37 <= {32'd0, sr_lo_s36} + {sr_hi_s36, 32'd0};
			yd_s37   <= {32'd0, yd_lo_s36} + {yd_hi_s36, 32'd0};
			xd_s37   <= {32'd0, xd_lo_s36} + {xd_hi_s36, 32'd0};
			mid_s37  <= mid_s36;
		end
	end

	assign xm  = mag32(mid_s37.x);
	assign ym  = mag32(mid_s37.y);
	assign vxm = mag32(mid_s37.vx);
	assign vym = mag32(mid_s37.vy);

	pmj_div #(.NUM_W(64), .DEN_W(32)) u_div_rr (
		.clk (clk), .en (en), .num (mid_s37.num_mag), .den (mid_s37.r),
		.neg (mid_s37.num_neg), .quot (q_rr)
	);

	pmj_div #(.NUM_W(64), .DEN_W(64)) u_div_dbx (
		.clk (clk), .en (en), .num ({ym, 32'd0}), .den (mid_s37.s),
		.neg (!mid_s37.y[31]), .quot (q_dbx)
	);

	pmj_div #(.NUM_W(64), .DEN_W(64)) u_div_dby (
		.clk (clk), .en (en), .num ({xm, 32'd0}), .den (mid_s37.s),
		.neg (mid_s37.x[31]), .quot (q_dby)
	);

	pmj_div #(.NUM_W(32 + FRAC_W), .DEN_W(32)) u_div_drx (
		.clk (clk), .en (en), .num ({(mid_s37.origin ? vxm : xm), FRAC_W'(0)}),
		.den (mid_s37.r), .neg (mid_s37.origin ? mid_s37.vx[31] : mid_s37.x[31]),
		.quot (q_drx)
	);

	pmj_div #(.NUM_W(32 + FRAC_W), .DEN_W(32)) u_div_dry (
		.clk (clk), .en (en), .num ({(mid_s37.origin ? vym : ym), FRAC_W'(0)}),
		.den (mid_s37.r), .neg (mid_s37.origin ? mid_s37.vy[31] : mid_s37.y[31]),
		.quot (q_dry)
	);

	pmj_div #(.NUM_W(96 + FRAC_W), .DEN_W(96)) u_div_drdx (
		.clk (clk), .en (en), .num ({yd_s37, FRAC_W'(0)}), .den (den3_s37),
		.neg (mid_s37.y[31] != mid_s37.d_neg), .quot (q_drdx)
	);

	pmj_div #(.NUM_W(96 + FRAC_W), .DEN_W(96)) u_div_drdy (
		.clk (clk), .en (en), .num ({xd_s37, FRAC_W'(0)}), .den (den3_s37),
		.neg (mid_s37.x[31] == mid_s37.d_neg), .quot (q_drdy)
	);

	assign xw = {{(CORDIC_W-32){mid_s37.x[31]}}, mid_s37.x};
	assign yw = {{(CORDIC_W-32){mid_s37.y[31]}}, mid_s37.y};

	always_ff @(posedge clk) begin
		if (en) begin
			if (mid_s37.x[31]) begin
				cx_s[0] <= -xw;
				cy_s[0] <= -yw;
				cz_s[0] <= mid_s37.y[31] ? -PI_Q30 : PI_Q30;
			end else begin
				cx_s[0] <= xw;
				cy_s[0] <= yw;
				cz_s[0] <= '0;
			end
			tail_s[0].origin <= mid_s37.origin;
			tail_s[0].vfast  <= mid_s37.r > {16'd0, speed_floor_q};
			tail_s[0].range  <= mid_s37.r[31] ? {RANGE_W{1'b1}} : mid_s37.r[RANGE_W-1:0];
			for (int k = 1; k < DIV_LAT; k++) begin
				tail_s[k] <= tail_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [CORDIC_W-1:0] ANG = cordic_angle(i);

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[i][CORDIC_W-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ANG;
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ANG;
				end
			end
		end
	end

	assign bsum = cz_s[CORDIC_STEPS] + ROUND_HALF;
	assign bear = WORD_W'(bsum >>> ROUND_SH);

	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_s[DIV_LAT-1].origin) begin
				meas.bearing     <= '0;
				meas.range       <= '0;
				meas.range_rate  <= '0;
				meas.dbearing_dx <= '0;
				meas.dbearing_dy <= '0;
				meas.drange_dx   <= '0;
				meas.drange_dy   <= '0;
				meas.drate_dx    <= '0;
				meas.drate_dy    <= '0;
				meas.drate_dvx   <= tail_s[DIV_LAT-1].vfast ? q_drx[UNIT_W-1:0] : '0;
				meas.drate_dvy   <= tail_s[DIV_LAT-1].vfast ? q_dry[UNIT_W-1:0] : '0;
				meas.at_origin   <= 1'b1;
			end else begin
				meas.bearing     <= bear;
				meas.range       <= tail_s[DIV_LAT-1].range;
				meas.range_rate  <= q_rr;
				meas.dbearing_dx <= q_dbx;
				meas.dbearing_dy <= q_dby;
				meas.drange_dx   <= q_drx[UNIT_W-1:0];
				meas.drange_dy   <= q_dry[UNIT_W-1:0];
				meas.drate_dx    <= q_drdx;
				meas.drate_dy    <= q_drdy;
				meas.drate_dvx   <= q_drx[UNIT_W-1:0];
				meas.drate_dvy   <= q_dry[UNIT_W-1:0];
				meas.at_origin   <= 1'b0;
			end
		end
	end

	`PMJ_ASSERT_IMP(a_origin_zero, meas.valid && meas.at_origin,
		meas.range == '0 && meas.bearing == '0, "origin item carries nonzero range or bearing")
	`PMJ_ASSERT_IMP(a_unit_bound, meas.valid,
		meas.drange_dx <= 18'sd65536 && meas.drange_dx >= -18'sd65536,
		"drange_dx outside the unit range")
	`PMJ_ASSERT_NXT(a_hold, !en, $stable(vld_s), "pipeline moved during a stall")
	`PMJ_ASSERT_NXT(a_enter, fire, vld_s[0], "accepted item did not enter the pipeline")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polar measurement and Jacobian core. Track
// states go in through the valid/ready channel, under random idling on both
// sides. Each item's measurement and Jacobian terms are predicted in
// wide integer arithmetic and compared, field by field, with the core's output.
// ----------------------------------------------------------------------------
module tb import pmj_pkg::*; ();

	typedef struct {
		logic signed [WORD_W-1:0] bearing;
		logic [RANGE_W-1:0]       range;
		logic signed [WORD_W-1:0] range_rate;
		logic signed [WORD_W-1:0] dbearing_dx;
		logic signed [WORD_W-1:0] dbearing_dy;
		logic signed [UNIT_W-1:0] drange_dx;
		logic signed [UNIT_W-1:0] drange_dy;
		logic signed [WORD_W-1:0] drate_dx;
		logic signed [WORD_W-1:0] drate_dy;
		logic signed [UNIT_W-1:0] drate_dvx;
		logic signed [UNIT_W-1:0] drate_dvy;
		logic                     at_origin;
	} meas_t;

	localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2, 1
	};
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [FLOOR_W-1:0] cfg_wdata;
	logic [FLOOR_W-1:0] speed_floor;

	int send_idle;
	int recv_idle;
	int mismatch_count;
	int cycle_count;
	meas_t pending_meas [$];

	pmj_track_if trk ();
	pmj_meas_if  ms ();

	polar_measurement_and_jacobian_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.track     (trk),
		.meas      (ms)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > n) probe = probe >> 2;
		while (probe != 0) begin
			if (n >= res + probe) begin
				n = n - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_quot(input bit neg, input logic [127:0] num,
		input logic [127:0] den);
		logic [127:0] q;
		if (den == 0) return 0;
		q = num / den;
		if (q > 128'h7FFF_FFFF) return neg ? -longint'(64'h8000_0000) : 64'h7FFF_FFFF;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint cordic_bearing(input longint x, input longint y);
		longint z;
		longint nx;
		longint ny;
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ATAN_Q30[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ATAN_Q30[i];
			end
			x = nx;
			y = ny;
		end
		return (z + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
	endfunction

	function automatic meas_t measure_track(input logic signed [31:0] px,
		input logic signed [31:0] pvx, input logic signed [31:0] py,
		input logic signed [31:0] pvy);
		meas_t m;
		longint sx, sy, svx, svy, drx, dry;
		logic [63:0] ax, ay, avx, avy, s, r, vr;
		logic signed [127:0] num, dd;
		logic [127:0] nmag, dmag, den3;
		m = '{default: '0};
		sx = px;
		sy = py;
		svx = pvx;
		svy = pvy;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		avx = (svx < 0) ? -svx : svx;
		avy = (svy < 0) ? -svy : svy;
		if (ax == 0 && ay == 0) begin
			vr = isqrt(avx * avx + avy * avy);
			if (vr > speed_floor) begin
				m.drate_dvx = UNIT_W'(clamp_quot(svx < 0, 128'(avx) << FRAC_W, 128'(vr)));
				m.drate_dvy = UNIT_W'(clamp_quot(svy < 0, 128'(avy) << FRAC_W, 128'(vr)));
			end
			m.at_origin = 1'b1;
		end else begin
			s = ax * ax + ay * ay;
			r = isqrt(s);
			num = sx * svx + sy * svy;
			dd = sx * svy - sy * svx;
			nmag = (num < 0) ? -num : num;
			dmag = (dd < 0) ? -dd : dd;
			den3 = 128'(s) * 128'(r);
			drx = clamp_quot(sx < 0, 128'(ax) << FRAC_W, 128'(r));
			dry = clamp_quot(sy < 0, 128'(ay) << FRAC_W, 128'(r));
			m.bearing = WORD_W'(cordic_bearing(sx, sy));
			m.range = (r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : r[30:0];
			m.range_rate = WORD_W'(clamp_quot(num < 0, nmag, 128'(r)));
			m.dbearing_dx = WORD_W'(clamp_quot(sy >= 0, 128'(ay) << (2 * FRAC_W), 128'(s)));
			m.dbearing_dy = WORD_W'(clamp_quot(sx < 0, 128'(ax) << (2 * FRAC_W), 128'(s)));
			m.drange_dx = UNIT_W'(drx);
			m.drange_dy = UNIT_W'(dry);
			m.drate_dx = WORD_W'(clamp_quot((sy < 0) != (dd < 0),
				(128'(ay) * dmag) << FRAC_W, den3));
			m.drate_dy = WORD_W'(clamp_quot((sx < 0) == (dd < 0),
				(128'(ax) * dmag) << FRAC_W, den3));
			m.drate_dvx = UNIT_W'(drx);
			m.drate_dvy = UNIT_W'(dry);
		end
		return m;
	endfunction

	task automatic send_track(input logic [31:0] px, input logic [31:0] pvx,
		input logic [31:0] py, input logic [31:0] pvy);
		meas_t m;
		m = measure_track(px, pvx, py, pvy);
		while ($urandom_range(99) < send_idle) begin
			trk.valid <= 1'b0;
			@(posedge clk);
		end
		trk.valid <= 1'b1;
		trk.pos_x <= px;
		trk.vel_x <= pvx;
		trk.pos_y <= py;
		trk.vel_y <= pvy;
		do @(posedge clk); while (!trk.ready);
		pending_meas.push_back(m);
	endtask

	task automatic drain();
		trk.valid <= 1'b0;
		while (pending_meas.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_floor(input logic [FLOOR_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		speed_floor = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		meas_t e;
		if (arst_n && ms.valid && ms.ready) begin
			if (pending_meas.size() == 0) begin
				$display("%0t unexpected item, expected none actual bearing %h",
					$time, ms.bearing);
				mismatch_count++;
			end else begin
				e = pending_meas.pop_front();
				check_field("bearing", e.bearing, ms.bearing);
				check_field("range", 32'(e.range), 32'(ms.range));
				check_field("range_rate", e.range_rate, ms.range_rate);
				check_field("dbearing_dx", e.dbearing_dx, ms.dbearing_dx);
				check_field("dbearing_dy", e.dbearing_dy, ms.dbearing_dy);
				check_field("drange_dx", 32'(e.drange_dx), 32'(ms.drange_dx));
				check_field("drange_dy", 32'(e.drange_dy), 32'(ms.drange_dy));
				check_field("drate_dx", e.drate_dx, ms.drate_dx);
				check_field("drate_dy", e.drate_dy, ms.drate_dy);
				check_field("drate_dvx", 32'(e.drate_dvx), 32'(ms.drate_dvx));
				check_field("drate_dvy", 32'(e.drate_dvy), 32'(ms.drate_dvy));
				check_field("at_origin", 32'(e.at_origin), 32'(ms.at_origin));
			end
		end
	end

	always @(posedge clk) begin
		ms.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_directed();
		send_track(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_track(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_track(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_track(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
		send_track(32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
		send_track(32'hFFFF_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_track(32'h0, 32'h1234, 32'hFFFF_0000, 32'h5678);
		send_track(32'h0, 32'h0, 32'h0000_0001, 32'h0);
		send_track(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
		send_track(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1);
		send_track(32'h0, 32'h0, 32'h0, 32'h0);
		send_track(32'h0, 32'h7, 32'h0, 32'h0);
		send_track(32'h0, 32'h8, 32'h0, 32'h0);
		send_track(32'h0, 32'hFFFF_FFF8, 32'h0, 32'h0);
		send_track(32'h0, 32'h6, 32'h0, 32'h5);
		send_track(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000);
		send_track(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
		send_track(32'h0300_0000, 32'hFFFF_0000, 32'hFD00_0000, 32'h0002_0000);
		drain();
	endtask

	task automatic test_speed_floor();
		write_floor(16'd0);
		send_track(32'h0, 32'h1, 32'h0, 32'h0);
		send_track(32'h0, 32'h0, 32'h0, 32'h0);
		send_track(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		write_floor(16'hFFFF);
		send_track(32'h0, 32'h0000_FFFF, 32'h0, 32'h0);
		send_track(32'h0, 32'h0001_0000, 32'h0, 32'h0);
		send_track(32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
		send_track(32'h0, 32'h0000_B505, 32'h0, 32'h0000_B505);
		drain();
	endtask

	function automatic logic [31:0] rand_coord(input int kind);
		case (kind)
			0: return 32'($signed($urandom_range(40)) - 20);
			1: return 32'($signed($urandom_range(131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random(input int n_items, input int s_idle, input int r_idle);
		int kind;
		logic [31:0] px, py, pvx, pvy;
		send_idle = s_idle;
		recv_idle = r_idle;
		write_floor($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(40)));
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(9);
			px = rand_coord(kind % 3);
			py = rand_coord($urandom_range(2));
			pvx = rand_coord($urandom_range(2));
			pvy = rand_coord($urandom_range(2));
			if (kind == 9) begin
				px = 0;
				py = 0;
			end else if (kind == 8) begin
				if ($urandom_range(1)) px = 0;
				else py = 0;
			end
			send_track(px, pvx, py, pvy);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		trk.valid = 1'b0;
		trk.pos_x = '0;
		trk.vel_x = '0;
		trk.pos_y = '0;
		trk.vel_y = '0;
		ms.ready = 1'b0;
		speed_floor = SPEED_FLOOR_RST;
		send_idle = 0;
		recv_idle = 0;
		mismatch_count = 0;
		cycle_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_speed_floor();
		test_random(200, 32, 74);
		test_random(200, 74, 32);
		test_random(200, 0, 0);
		if (mismatch_count == 0 && pending_meas.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
